// ===== sv/tti_pkg.sv =====
// Shared types, constants and helpers for the text-to-integer parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package tti_pkg;

    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int SYM_SLOTS       = 16;
    localparam int CHAR_W          = 8;
    localparam int VALUE_W         = 32;
    localparam int BASE_W          = 5;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int ACC_EXT_W       = VALUE_W + BASE_W;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    localparam logic [VALUE_W-1:0] MIN_MAG = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYMBOLS_LOW  = 2'd0,
        CFG_SYMBOLS_HIGH = 2'd1,
        CFG_BASE_LENGTH  = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_SPACE = 4'b0001,
        PH_SIGN  = 4'b0010,
        PH_DIGIT = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    typedef logic [SYM_SLOTS-1:0][CHAR_W-1:0] t_sym_tab;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               overflowed;
        logic               base_invalid;
    } t_result;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

// ===== sv/tti_table_check.sv =====
// Symbol table checker: flags a digit alphabet that cannot be used.
// Depends on tti_pkg; result is registered once per cycle.
`default_nettype none

module tti_table_check
    import tti_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_sym_tab          i_symbols,
    input  wire logic [BASE_W-1:0] i_base_length,
    output logic                   o_table_valid
);

    logic                 r_table_valid;
    logic                 n_table_valid;
    logic [SYM_SLOTS-1:0] in_use;

    always_comb begin
        n_table_valid = (i_base_length >= BASE_W'(2))
                     && (i_base_length <= BASE_W'(MAX_SYMBOLS));
        for (int i = 0; i < SYM_SLOTS; i++) begin
            in_use[i] = (i < MAX_SYMBOLS) && (BASE_W'(i) < i_base_length);
        end
        for (int i = 0; i < SYM_SLOTS; i++) begin
            if (in_use[i]) begin
                if ((i_symbols[i] == CH_NUL) || (i_symbols[i] == CH_PLUS)
                    || (i_symbols[i] == CH_MINUS) || is_blank(i_symbols[i])) begin
                    n_table_valid = 1'b0;
                end
                for (int j = i + 1; j < SYM_SLOTS; j++) begin
                    if (in_use[j] && (i_symbols[j] == i_symbols[i])) begin
                        n_table_valid = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_valid <= 1'b0;
        end else begin
            r_table_valid <= n_table_valid;
        end
    end

    assign o_table_valid = r_table_valid;

endmodule

`default_nettype wire

// ===== sv/tti_parser.sv =====
// Per-character parse engine: phase, sign, accumulator and overflow state.
// Depends on tti_pkg; one character is consumed per step.
`default_nettype none

module tti_parser
    import tti_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [CHAR_W-1:0] i_char,
    input  wire logic              i_last,
    input  wire logic              i_table_valid,
    input  wire t_sym_tab          i_symbols,
    input  wire logic [BASE_W-1:0] i_base_length,
    output t_result                o_result
);

    localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    t_phase               r_phase,    n_phase;
    logic                 r_negative, n_negative;
    logic [VALUE_W-1:0]   r_acc,      n_acc;
    logic                 r_ovf,      n_ovf;

    logic                 found;
    logic                 digit_hit;
    logic [IDX_W-1:0]     digit_idx;
    logic [ACC_EXT_W-1:0] acc_next;

    // lowest matching slot wins
    always_comb begin
        found     = 1'b0;
        digit_idx = '0;
        for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
            if ((BASE_W'(k) < i_base_length) && (i_symbols[k] == i_char)) begin
                found     = 1'b1;
                digit_idx = IDX_W'(k);
            end
        end
        digit_hit = found && i_table_valid;
        acc_next  = ACC_EXT_W'(r_acc) * ACC_EXT_W'(i_base_length)
                  + ACC_EXT_W'(digit_idx);
    end

    always_comb begin
        n_phase    = r_phase;
        n_negative = r_negative;
        n_acc      = r_acc;
        n_ovf      = r_ovf;
        unique case (r_phase) inside
            PH_SPACE, PH_SIGN: begin
                if ((r_phase == PH_SPACE) && is_blank(i_char)) begin
                    n_phase = PH_SPACE;
                end else if (i_char == CH_MINUS) begin
                    n_negative = !r_negative;
                    n_phase    = PH_SIGN;
                end else if (i_char == CH_PLUS) begin
                    n_phase = PH_SIGN;
                end else if (digit_hit) begin
                    n_acc   = acc_next[VALUE_W-1:0];
                    n_ovf   = r_ovf || (acc_next > ACC_EXT_W'(MIN_MAG));
                    n_phase = PH_DIGIT;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_DIGIT: begin
                if (digit_hit) begin
                    n_acc = acc_next[VALUE_W-1:0];
                    n_ovf = r_ovf || (acc_next > ACC_EXT_W'(MIN_MAG));
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_SPACE;
            end
        endcase
    end

    always_comb begin
        if (!i_table_valid) begin
            o_result.value        = '0;
            o_result.overflowed   = 1'b0;
            o_result.base_invalid = 1'b1;
        end else begin
            o_result.value        = n_negative ? (VALUE_W'(0) - n_acc) : n_acc;
            o_result.overflowed   = n_ovf || ((n_acc == MIN_MAG) && !n_negative);
            o_result.base_invalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SPACE;
            r_negative <= 1'b0;
            r_acc      <= '0;
            r_ovf      <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                // string ends: start over for the next one
                r_phase    <= PH_SPACE;
                r_negative <= 1'b0;
                r_acc      <= '0;
                r_ovf      <= 1'b0;
            end else begin
                r_phase    <= n_phase;
                r_negative <= n_negative;
                r_acc      <= n_acc;
                r_ovf      <= n_ovf;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/text_to_integer_custom_base_core.sv =====
// Top level of the text-to-integer parser with a configurable digit alphabet.
// Depends on tti_pkg, tti_table_check and tti_parser.
//
//  channel  direction  handshake                 payload
//  input    in         i_in_valid / o_in_stall   i_char_in, i_end_of_string
//  result   out        o_out_valid / i_out_stall o_value, o_overflowed, o_base_invalid
//  config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One character per cycle sustained while the input is not stalled; the input
// register feeds the combinational multiply-add of the accumulator, and the
// last character of a string steps it straight into the result register.
// Reset (synchronous, active low) clears the parse state, the table and all valids.
// A stalled result holds; the input side stalls only when the last character
// of a string waits for a full result register, or during a config transaction.
`default_nettype none

module text_to_integer_custom_base_core
    import tti_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [CHAR_W-1:0]     i_char_in,
    input  wire logic                  i_end_of_string,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic signed [VALUE_W-1:0]  o_value,
    output logic                       o_overflowed,
    output logic                       o_base_invalid,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0] r_sym_low;
    logic [CFG_DATA_W-1:0] r_sym_high;
    logic [BASE_W-1:0]     r_base_len;
    t_sym_tab              symbols;

    logic                  r_in_vld;
    logic [CHAR_W-1:0]     r_char;
    logic                  r_last;
    logic                  r_out_vld;
    t_result               r_result;

    logic                  cfg_wr;
    logic                  in_accept;
    logic                  out_free;
    logic                  step;
    logic                  table_valid;
    t_result               step_result;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign symbols     = {r_sym_high, r_sym_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_low  <= '0;
            r_sym_high <= '0;
            r_base_len <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_SYMBOLS_LOW:  r_sym_low  <= i_cfg_data;
                CFG_SYMBOLS_HIGH: r_sym_high <= i_cfg_data;
                CFG_BASE_LENGTH:  r_base_len <= i_cfg_data[BASE_W-1:0];
                default: begin
                    // unmapped index: drop the transaction
                end
            endcase
        end
    end

    tti_table_check #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_table_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_symbols     (symbols),
        .i_base_length (r_base_len),
        .o_table_valid (table_valid)
    );

    // a non-final character never needs the result register
    assign out_free   = !r_out_vld || !i_out_stall;
    assign step       = r_in_vld && (!r_last || out_free);
    // hold inputs while a config write is taken
    assign o_in_stall = (r_in_vld && !step) || cfg_wr;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_accept) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_char <= i_char_in;
            r_last <= i_end_of_string;
        end
    end

    tti_parser #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_char        (r_char),
        .i_last        (r_last),
        .i_table_valid (table_valid),
        .i_symbols     (symbols),
        .i_base_length (r_base_len),
        .o_result      (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step && r_last) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_last) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_value        = r_result.value;
    assign o_overflowed   = r_result.overflowed;
    assign o_base_invalid = r_result.base_invalid;

endmodule

`default_nettype wire

// ===== sv/tti_checker.sv =====
// Port-level checker for text_to_integer_custom_base_core, bound to the top.
// Depends on tti_pkg for widths only.
`default_nettype none

module tti_checker
    import tti_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire logic [VALUE_W-1:0]    o_value,
    input wire logic                  o_overflowed,
    input wire logic                  o_base_invalid,
    input wire logic                  i_cfg_valid,
    input wire logic                  o_cfg_ready
);

    // a stalled result transaction stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_value) && $stable(o_overflowed)
             && $stable(o_base_invalid)))
        else $error("result changed while stalled");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_base_invalid) |-> ((o_value == '0) && !o_overflowed))
        else $error("rejected table gave nonzero result");

    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> o_in_stall)
        else $error("input accepted during config transaction");

    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && !i_cfg_valid && i_in_valid) |-> !o_in_stall)
        else $error("input stalled with empty result register");

    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind text_to_integer_custom_base_core tti_checker u_tti_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_value        (o_value),
    .o_overflowed   (o_overflowed),
    .o_base_invalid (o_base_invalid),
    .i_cfg_valid    (i_cfg_valid),
    .o_cfg_ready    (o_cfg_ready)
);

`default_nettype wire

// ===== verif/text_to_integer_custom_base_core_test.sv =====
// Self-checking testbench for text_to_integer_custom_base_core: strings are streamed one
// character per transaction and each parsed result is checked against an in-bench predictor.
// Depends on tti_pkg and the core; random gaps on the input channel and stalls on the result channel.
`timescale 1ns / 1ps

module text_to_integer_custom_base_core_test;
    import tti_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eos;
    } t_text_char;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [CHAR_W-1:0]     i_char_in = '0;
    logic                  i_end_of_string = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic signed [VALUE_W-1:0] o_value;
    logic                  o_overflowed;
    logic                  o_base_invalid;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Symbol table as the block should hold it
    logic [63:0]      tab_lo = '0;
    logic [63:0]      tab_hi = '0;
    logic [BASE_W-1:0] tab_len = '0;

    // Parse state of the string in flight
    t_phase           ps_phase = PH_SPACE;
    bit               ps_neg = 1'b0;
    logic [VALUE_W-1:0] ps_mag = '0;
    bit               ps_ovf = 1'b0;

    t_text_char text_q[$];
    t_result    parsed_q[$];
    int         queued_chars = 0;
    int         fail_count = 0;
    int         gap_left = 0;
    int         stall_left = 0;
    bit         quiet_mode = 1'b0;

    text_to_integer_custom_base_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_in      (i_char_in),
        .i_end_of_string(i_end_of_string),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_value        (o_value),
        .o_overflowed   (o_overflowed),
        .o_base_invalid (o_base_invalid),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(10_000_000);
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [7:0] digit_sym(input int idx);
        return (idx < 8) ? tab_lo[idx*8 +: 8] : tab_hi[(idx-8)*8 +: 8];
    endfunction

    function automatic bit whitespace(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit reserved_char(input logic [7:0] c);
        return whitespace(c) || c == CH_NUL || c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic bit table_ok();
        logic [7:0] s;
        int         len;
        len = int'(tab_len);
        if (len < 2 || len > MAX_SYMBOLS_DEF)
            return 1'b0;
        for (int i = 0; i < len; i++) begin
            s = digit_sym(i);
            if (reserved_char(s))
                return 1'b0;
            for (int j = i + 1; j < len; j++)
                if (digit_sym(j) == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the parse by one character; push the parsed result on the last one
    function automatic void advance_parse(input logic [7:0] c, input logic last);
        bit              ok;
        bit              used;
        bit              hit;
        longint unsigned acc;
        t_result         res;
        ok   = table_ok();
        used = 1'b0;
        hit  = 1'b0;
        if (ps_phase == PH_SPACE) begin
            if (whitespace(c))
                used = 1'b1;
            else
                ps_phase = PH_SIGN;
        end
        if (!used && ps_phase == PH_SIGN) begin
            if (c == CH_MINUS) begin
                ps_neg = !ps_neg;
                used   = 1'b1;
            end else if (c == CH_PLUS) begin
                used = 1'b1;
            end else begin
                ps_phase = PH_DIGIT;
            end
        end
        if (!used && ps_phase == PH_DIGIT) begin
            if (ok) begin
                for (int k = 0; k < int'(tab_len); k++) begin
                    if (!hit && digit_sym(k) == c) begin
                        acc = 64'(ps_mag);
                        acc = acc * 64'(tab_len) + 64'(k);
                        if (acc > 64'h8000_0000)
                            ps_ovf = 1'b1;
                        ps_mag = acc[31:0];
                        hit    = 1'b1;
                    end
                end
            end
            if (!hit)
                ps_phase = PH_DONE;
        end
        if (last) begin
            if (!ok) begin
                res.value        = '0;
                res.overflowed   = 1'b0;
                res.base_invalid = 1'b1;
            end else begin
                res.value        = ps_neg ? (32'd0 - ps_mag) : ps_mag;
                res.overflowed   = ps_ovf || (ps_mag == MIN_MAG && !ps_neg);
                res.base_invalid = 1'b0;
            end
            parsed_q.push_back(res);
            ps_phase = PH_SPACE;
            ps_neg   = 1'b0;
            ps_mag   = '0;
            ps_ovf   = 1'b0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] pick_blank();
        return ($urandom_range(0, 2) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
    endfunction

    function automatic logic [7:0] pick_reserved();
        case ($urandom_range(0, 4))
            0:       return CH_NUL;
            1:       return CH_PLUS;
            2:       return CH_MINUS;
            3:       return CH_SPACE;
            default: return pick_blank();
        endcase
    endfunction

    // Input channel: hold the payload while stalled, advance on acceptance
    always @(posedge i_clk) begin : drive_chars
        t_text_char nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                advance_parse(i_char_in, i_end_of_string);
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (text_q.size() > 0) begin
                    nxt = text_q.pop_front();
                    i_in_valid      <= 1'b1;
                    i_char_in       <= nxt.ch;
                    i_end_of_string <= nxt.eos;
                    gap_left = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result channel: compare each transaction with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        bit      nxt_stall;
        int      r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (parsed_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: value %0d ovf %0b inv %0b",
                                 o_value, o_overflowed, o_base_invalid);
                end else begin
                    want = parsed_q.pop_front();
                    if (o_value !== want.value || o_overflowed !== want.overflowed ||
                        o_base_invalid !== want.base_invalid) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected value %0d ovf %0b inv %0b, ",
                                      "got %0d %0b %0b"},
                                     $signed(want.value), want.overflowed, want.base_invalid,
                                     o_value, o_overflowed, o_base_invalid);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                nxt_stall = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (quiet_mode || r < 70) begin
                    nxt_stall = 1'b0;
                end else begin
                    nxt_stall  = 1'b1;
                    stall_left = (r < 90) ? $urandom_range(0, 2) :
                                 (r < 98) ? $urandom_range(3, 10) : $urandom_range(15, 40);
                end
            end
            i_out_stall <= nxt_stall;
        end
    end

    // Call at a rising edge; returns at the edge that accepted the write
    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SYMBOLS_LOW:  tab_lo = data;
            CFG_SYMBOLS_HIGH: tab_hi = data;
            CFG_BASE_LENGTH:  tab_len = data[BASE_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every character is taken and every result is back, then let the pipe drain
    task automatic settle();
        do @(negedge i_clk);
        while (text_q.size() != 0 || i_in_valid || parsed_q.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic put_char(input logic [7:0] c, input logic e);
        text_q.push_back('{ch: c, eos: e});
        queued_chars++;
    endtask

    task automatic queue_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i], close && i == s.len() - 1);
    endtask

    task automatic program_table(input int which);
        logic [7:0]  syms[16];
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] ld;
        int          len;
        int          r;
        int          slot;
        bit          clash;
        for (int k = 0; k < 16; k++) begin
            do begin
                syms[k] = 8'($urandom_range(1, 255));
                clash   = reserved_char(syms[k]);
                for (int j = 0; j < k; j++)
                    if (syms[j] == syms[k])
                        clash = 1'b1;
            end while (clash);
        end
        r = $urandom_range(0, 99);
        case (which)
            0: len = 2;
            1: len = 16;
            2: len = 31;
            3: len = 0;
            default: begin
                if (r < 75) begin
                    len = $urandom_range(2, 16);
                end else if (r < 85) begin
                    case ($urandom_range(0, 2))
                        0:       len = 0;
                        1:       len = 1;
                        default: len = $urandom_range(17, 31);
                    endcase
                end else if (r < 93) begin
                    len = $urandom_range(2, 16);
                    syms[$urandom_range(0, len - 1)] = pick_reserved();
                end else begin
                    len  = $urandom_range(2, 16);
                    slot = $urandom_range(1, len - 1);
                    syms[slot] = syms[$urandom_range(0, slot - 1)];
                end
            end
        endcase
        // Slots past the base length are don't-care; fill them with anything
        if ($urandom_range(0, 1))
            for (int k = len; k < 16; k++)
                syms[k] = 8'($urandom_range(0, 255));
        for (int k = 0; k < 8; k++) begin
            lo[k*8 +: 8] = syms[k];
            hi[k*8 +: 8] = syms[k+8];
        end
        ld = {$urandom, $urandom};
        ld[BASE_W-1:0] = BASE_W'(len);
        @(posedge i_clk);
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_BASE_LENGTH, ld);
            write_reg(CFG_SYMBOLS_LOW, lo);
            write_reg(CFG_SYMBOLS_HIGH, hi);
        end else begin
            write_reg(CFG_SYMBOLS_HIGH, hi);
            write_reg(CFG_SYMBOLS_LOW, lo);
            write_reg(CFG_BASE_LENGTH, ld);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Blanks, signs, table digits (random bytes for an unusable length) and optional trailing junk
    task automatic queue_number(input bit close);
        logic [7:0]      txt[$];
        int              dig[$];
        int              b;
        int              n;
        int              r;
        int              span;
        longint unsigned p;
        longint unsigned m;
        b = int'(tab_len);
        if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 3)) txt.push_back(pick_blank());
        if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 3)) txt.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        if (b >= 2 && b <= 16) begin
            span = 1;
            p    = 64'(b);
            while (p < 64'h1_0000_0000) begin
                p = p * 64'(b);
                span++;
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                // magnitudes around the signed limit and the 32-bit wrap
                case ($urandom_range(0, 3))
                    0:       m = 64'h8000_0000;
                    1:       m = 64'h7FFF_FFFF;
                    2:       m = 64'h8000_0001;
                    default: m = 64'hFFFF_FFFF;
                endcase
                do begin
                    dig.push_front(int'(m % 64'(b)));
                    m = m / 64'(b);
                end while (m != 0);
            end else begin
                n = (r < 75) ? $urandom_range(1, span - 1) : $urandom_range(span - 1, span + 2);
                repeat (n) dig.push_back($urandom_range(0, b - 1));
            end
            foreach (dig[i])
                txt.push_back(digit_sym(dig[i]));
        end else begin
            repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(0, 255)));
        foreach (txt[i])
            put_char(txt[i], close && i == txt.size() - 1);
    endtask

    initial begin : stimulus
        int start;
        int r;
        int n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Hex-like alphabet with 8'hFF as the top digit
        write_reg(CFG_SYMBOLS_LOW, 64'h3736_3534_3332_3130);
        write_reg(CFG_SYMBOLS_HIGH, 64'hFF65_6463_6261_3938);
        write_reg(CFG_BASE_LENGTH, 64'd16);
        i_cfg_valid <= 1'b0;
        queue_text("-80000000", 1'b1);
        queue_text("+80000000", 1'b1);
        put_char(CH_NUL, 1'b1);
        queue_text("- 5", 1'b1);
        put_char(8'hFF, 1'b1);
        queue_text("1", 1'b0);
        settle();

        // Table turns invalid while a string is open
        write_reg(CFG_BASE_LENGTH, 64'd1);
        i_cfg_valid <= 1'b0;
        queue_text("2", 1'b1);
        queue_text("7", 1'b1);
        queue_text(" -", 1'b0);
        settle();
        write_reg(CFG_BASE_LENGTH, 64'd10);
        i_cfg_valid <= 1'b0;
        queue_text("4", 1'b1);
        settle();

        for (int ph = 0; ph < 10; ph++) begin
            program_table(ph);
            quiet_mode = (ph % 4 == 3);
            start = queued_chars;
            while (queued_chars - start < 102) begin
                r = $urandom_range(0, 99);
                if (r < 82) begin
                    queue_number(1'b1);
                end else if (r < 92) begin
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++)
                        put_char(8'($urandom_range(0, 255)), k == n - 1);
                end else begin
                    case ($urandom_range(0, 2))
                        0: begin
                            put_char(CH_MINUS, 1'b0);
                            put_char(pick_blank(), 1'b0);
                            queue_number(1'b1);
                        end
                        1: begin
                            n = $urandom_range(1, 4);
                            for (int k = 0; k < n; k++)
                                put_char(pick_blank(), k == n - 1);
                        end
                        default: begin
                            n = $urandom_range(1, 4);
                            for (int k = 0; k < n; k++)
                                put_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, k == n - 1);
                        end
                    endcase
                end
            end
            // Leave a string open across the next table change now and then
            if (ph < 9 && $urandom_range(0, 2) == 0)
                queue_number(1'b0);
            settle();
        end

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
